// ===== src/elg_pkg.sv =====
// Package: shared constants and types for the ElGamal decryption block.
`timescale 1ns / 1ps
package elg_pkg;
    localparam int unsigned WIDTH_DEF = 32;
    localparam logic [31:0] RESET_MODULUS = 32'd23;
    localparam logic [31:0] RESET_PRIVATE_KEY = 32'd2;
    localparam logic [0:0] REG_MODULUS = 1'b0;
    localparam logic [0:0] REG_PRIVATE_KEY = 1'b1;

    // operation codes for the shared arithmetic unit
    typedef enum logic [1:0] {
        OP_MULMOD = 2'd0,
        OP_DIVMOD = 2'd1,
        OP_REDUCE = 2'd2
    } op_t;
endpackage

// ===== src/elg_arith.sv =====
// Shared multi-cycle unit: modular multiply, reduce, and integer divide.
`timescale 1ns / 1ps
module elg_arith #(
    parameter int unsigned WIDTH = elg_pkg::WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  elg_pkg::op_t      op,
    input  logic [WIDTH-1:0]  opa,
    input  logic [WIDTH-1:0]  opb,
    input  logic [WIDTH-1:0]  modulus,
    output logic              done,
    output logic [WIDTH-1:0]  result,
    output logic [WIDTH-1:0]  quotient
);
    localparam int unsigned CW = $clog2(WIDTH + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    elg_pkg::op_t      op_reg, op_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [WIDTH-1:0]  acc_reg, acc_next;     // remainder / product accumulator
    logic [WIDTH-1:0]  sh_reg, sh_next;       // bits consumed msb first
    logic [WIDTH-1:0]  mul_reg, mul_next;     // multiplicand or divisor
    logic [WIDTH-1:0]  quo_reg, quo_next;

    logic [WIDTH:0]    dbl;
    logic [WIDTH:0]    dbl_red;
    logic [WIDTH:0]    sum;
    logic [WIDTH-1:0]  sum_red;

    // one shift-and-reduce step per cycle, msb first
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        mul_next  = mul_reg;
        quo_next  = quo_reg;
        dbl       = {acc_reg, sh_reg[WIDTH-1]};
        dbl_red   = '0;
        sum       = '0;
        sum_red   = '0;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                op_next   = op;
                cnt_next  = CW'(WIDTH);
                acc_next  = '0;
                quo_next  = '0;
                case (op)
                    elg_pkg::OP_MULMOD: begin
                        sh_next  = opb;
                        mul_next = opa;
                    end
                    elg_pkg::OP_DIVMOD: begin
                        sh_next  = opa;
                        mul_next = opb;
                    end
                    default: begin
                        sh_next  = opa;
                        mul_next = modulus;
                    end
                endcase
            end
        end else begin
            case (op_reg)
                elg_pkg::OP_MULMOD: begin
                    // acc = 2*acc mod m, then add mul if bit set (mul < m)
                    dbl = {acc_reg, 1'b0};
                    dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
                    sum = dbl_red + (sh_reg[WIDTH-1] ? {1'b0, mul_reg} : '0);
                    sum_red = (sum >= {1'b0, modulus}) ? WIDTH'(sum - {1'b0, modulus})
                                                       : WIDTH'(sum);
                    acc_next = sum_red;
                end
                default: begin
                    // restoring division of sh by mul
                    if (dbl >= {1'b0, mul_reg}) begin
                        acc_next = WIDTH'(dbl - {1'b0, mul_reg});
                        quo_next = {quo_reg[WIDTH-2:0], 1'b1};
                    end else begin
                        acc_next = WIDTH'(dbl);
                        quo_next = {quo_reg[WIDTH-2:0], 1'b0};
                    end
                end
            endcase
            sh_next  = {sh_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        mul_reg <= mul_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign result   = acc_reg;
    assign quotient = quo_reg;
endmodule

// ===== src/elg_ctrl.sv =====
// Sequencer: exponentiation, extended Euclid and final multiply.
`timescale 1ns / 1ps
module elg_ctrl #(
    parameter int unsigned WIDTH = elg_pkg::WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WIDTH-1:0]  c1,
    input  logic [WIDTH-1:0]  c2,
    input  logic [WIDTH-1:0]  modulus,
    input  logic [WIDTH-1:0]  exponent,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WIDTH-1:0]  out_pt,
    output logic [WIDTH-1:0]  out_k
);
    typedef enum logic [3:0] {
        S_IDLE, S_RED1, S_RED2, S_EXP, S_MULR, S_SQR,
        S_EUC, S_DIV, S_QS, S_QM, S_FIN, S_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [WIDTH-1:0]  m_reg, m_next;
    logic [WIDTH-1:0]  e_reg, e_next;
    logic [WIDTH-1:0]  base_reg, base_next;
    logic [WIDTH-1:0]  c2_reg, c2_next;
    logic [WIDTH-1:0]  r_reg, r_next;         // pow result, later Euclid r
    logic [WIDTH-1:0]  k_reg, k_next;
    logic [WIDTH-1:0]  orr_reg, orr_next;
    logic [WIDTH-1:0]  os_reg, os_next;
    logic [WIDTH-1:0]  s_reg, s_next;
    logic [WIDTH-1:0]  nr_reg, nr_next;
    logic [WIDTH-1:0]  pt_reg, pt_next;
    logic              start;
    elg_pkg::op_t      op;
    logic [WIDTH-1:0]  opa, opb;
    logic              adone;
    logic [WIDTH-1:0]  ares, aquo;
    logic              mbig;
    logic [WIDTH-1:0]  ns;

    elg_arith #(.WIDTH(WIDTH)) u_arith (
        .aclk(aclk), .aresetn(aresetn), .start(start), .op(op),
        .opa(opa), .opb(opb), .modulus(m_reg), .done(adone),
        .result(ares), .quotient(aquo)
    );

    assign mbig = (m_reg > WIDTH'(1));

    // new coefficient: old s minus q*s, kept in 0..m-1
    always_comb begin
        ns = (os_reg >= ares) ? os_reg - ares : os_reg + (m_reg - ares);
    end

    always_comb begin
        state_next = state_reg;
        m_next = m_reg; e_next = e_reg; base_next = base_reg; c2_next = c2_reg;
        r_next = r_reg; k_next = k_reg; orr_next = orr_reg; os_next = os_reg;
        s_next = s_reg; nr_next = nr_reg; pt_next = pt_reg;
        start = 1'b0; op = elg_pkg::OP_REDUCE; opa = '0; opb = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    m_next = modulus; e_next = exponent;
                    base_next = c1; c2_next = c2;
                    state_next = S_RED1;
                end
            end
            S_RED1: begin
                if (!mbig) begin
                    k_next = '0; pt_next = '0; state_next = S_OUT;
                end else begin
                    start = 1'b1; op = elg_pkg::OP_REDUCE; opa = base_reg;
                    state_next = S_RED2;
                end
            end
            S_RED2: begin
                if (adone) begin
                    base_next = ares; r_next = WIDTH'(1); state_next = S_EXP;
                end
            end
            S_EXP: begin
                if (e_reg == '0) begin
                    k_next = r_reg; orr_next = r_reg; r_next = m_reg;
                    os_next = WIDTH'(1); s_next = '0; state_next = S_EUC;
                end else if (e_reg[0]) begin
                    start = 1'b1; op = elg_pkg::OP_MULMOD; opa = r_reg; opb = base_reg;
                    state_next = S_MULR;
                end else begin
                    start = 1'b1; op = elg_pkg::OP_MULMOD; opa = base_reg; opb = base_reg;
                    state_next = S_SQR;
                end
            end
            S_MULR: begin
                if (adone) begin
                    r_next = ares;
                    start = 1'b1; op = elg_pkg::OP_MULMOD; opa = base_reg; opb = base_reg;
                    state_next = S_SQR;
                end
            end
            S_SQR: begin
                if (adone) begin
                    base_next = ares; e_next = e_reg >> 1; state_next = S_EXP;
                end
            end
            S_EUC: begin
                // coefficient is below m, so it goes in as the multiplicand
                if (r_reg == '0) begin
                    start = 1'b1; op = elg_pkg::OP_MULMOD; opa = os_reg; opb = c2_reg;
                    state_next = S_FIN;
                end else begin
                    start = 1'b1; op = elg_pkg::OP_DIVMOD; opa = orr_reg; opb = r_reg;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (adone) begin
                    nr_next = ares; state_next = S_QS;
                    start = 1'b1; op = elg_pkg::OP_REDUCE; opa = aquo;
                end
            end
            S_QS: begin
                // reduce quotient, then multiply by s
                if (adone) begin
                    start = 1'b1; op = elg_pkg::OP_MULMOD; opa = ares; opb = s_reg;
                    state_next = S_QM;
                end
            end
            S_QM: begin
                // advance the remainder and coefficient pairs
                if (adone) begin
                    orr_next = r_reg; r_next = nr_reg;
                    os_next = s_reg; s_next = ns;
                    state_next = S_EUC;
                end
            end
            S_FIN: begin
                if (adone) begin
                    pt_next = ares; state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        m_reg <= m_next; e_reg <= e_next; base_reg <= base_next; c2_reg <= c2_next;
        k_reg <= k_next; pt_reg <= pt_next; nr_reg <= nr_next;
        orr_reg <= orr_next; r_reg <= r_next;
        os_reg <= os_next; s_reg <= s_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_pt    = pt_reg;
    assign out_k     = k_reg;
endmodule

// ===== src/elgamal_decrypt.sv =====
// Top level: ElGamal decryption with stream channels and a register port.
// Usage:
//   s_axis carries one ciphertext (cipher_first low, cipher_second high).
//   m_axis returns plaintext, shared_secret and plaintext_zero.
//   cfg writes modulus (index 0) and private_key (index 1) while idle.
// Sequence: each modular multiply, reduce or divide occupies the shared
//   shift-and-subtract unit. Exponentiation spends one squaring per key
//   bit, preceded by a multiply when the bit is set, and each Euclid step
//   is a divide, a reduce of the quotient and a multiply.
// Throughput: one item at a time; s_axis_tready is high only when idle.
// Reset: registers return to modulus 23, private_key 2; sequencer idles.
// Stall: the result holds on m_axis until taken; no new item is accepted
//   until then.
`timescale 1ns / 1ps
module elgamal_decrypt #(
    parameter int unsigned WIDTH = elg_pkg::WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [2*WIDTH-1:0]  s_axis_tdata,   // cipher_first, cipher_second
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [2*WIDTH-1:0]  m_axis_tdata,   // plaintext, shared_secret
    output logic                m_axis_tuser,   // plaintext_zero
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [WIDTH-1:0]    cfg_data
);
    logic [WIDTH-1:0] modulus_reg, pkey_reg;
    logic [WIDTH-1:0] pt, k;

    // hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= WIDTH'(elg_pkg::RESET_MODULUS);
            pkey_reg    <= WIDTH'(elg_pkg::RESET_PRIVATE_KEY);
        end else if (cfg_valid) begin
            if (cfg_index == elg_pkg::REG_MODULUS) modulus_reg <= cfg_data;
            else pkey_reg <= cfg_data;
        end
    end
    assign cfg_ready = 1'b1;

    elg_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .c1(s_axis_tdata[WIDTH-1:0]), .c2(s_axis_tdata[2*WIDTH-1:WIDTH]),
        .modulus(modulus_reg), .exponent(pkey_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_pt(pt), .out_k(k)
    );

    assign m_axis_tdata = {k, pt};
    assign m_axis_tuser = (pt == '0);
endmodule

// ===== bench/elgamal_decrypt_test.sv =====
// Testbench for the ElGamal decryption block: directed table, key-register extremes, then random ciphertexts.
`timescale 1ns / 1ps
module elgamal_decrypt_test;
    localparam int W = 32;
    localparam int IDLE_LIMIT = 100000;

    typedef struct packed {
        logic [W-1:0] plain;
        logic [W-1:0] secret;
        logic         zero;
    } decrypt_result_t;

    typedef struct {
        logic [W-1:0]    c1;
        logic [W-1:0]    c2;
        bit              known;
        decrypt_result_t res;
    } cipher_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [2*W-1:0]   s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [2*W-1:0]   m_axis_tdata;
    logic             m_axis_tuser;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = 1'b0;
    logic [W-1:0]     cfg_data = '0;

    logic [W-1:0]     q_mod;
    logic [W-1:0]     x_key;
    decrypt_result_t  plain_queue[$];
    int               errors = 0;
    int               idle_cycles = 0;
    bit               hold_off = 1'b0;
    bit               hold_done = 1'b0;

    elgamal_decrypt u_top (.*);

    always #1 aclk = ~aclk;

    // modular arithmetic on 64-bit values to avoid overflow
    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] m);
        return (a * b) % m;
    endfunction

    function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e,
                                           logic [63:0] m);
        logic [63:0] r;
        r = 1 % m;
        b = b % m;
        while (e != 0) begin
            if (e[0]) r = mulmod(r, b, m);
            b = mulmod(b, b, m);
            e = e >> 1;
        end
        return r;
    endfunction

    // Bezout coefficient of k, kept in 0..m-1
    function automatic logic [63:0] inverse_of(logic [63:0] k, logic [63:0] m);
        logic [63:0] old_r, r, old_s, s, qt, nr, ns, prod;
        old_r = k; r = m; old_s = 1 % m; s = 0;
        while (r != 0) begin
            qt = old_r / r;
            nr = old_r - qt * r;
            prod = mulmod(qt % m, s, m);
            ns = (old_s >= prod) ? old_s - prod : old_s + (m - prod);
            old_r = r; r = nr; old_s = s; s = ns;
        end
        return old_s;
    endfunction

    function automatic decrypt_result_t decrypt(logic [W-1:0] c1, logic [W-1:0] c2);
        decrypt_result_t res;
        logic [63:0] k, pt;
        k = 0; pt = 0;
        if (q_mod >= 2) begin
            k = powmod(c1, x_key, q_mod);
            pt = mulmod(c2 % q_mod, inverse_of(k, q_mod), q_mod);
        end
        res.plain = pt[W-1:0];
        res.secret = k[W-1:0];
        res.zero = (pt == 0);
        return res;
    endfunction

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, check each transfer
    initial begin : receiver
        int gap;
        decrypt_result_t got, want;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (6000) @(posedge aclk);
                hold_done = 1'b1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk iff m_axis_tvalid);
            got.plain = m_axis_tdata[W-1:0];
            got.secret = m_axis_tdata[2*W-1:W];
            got.zero = m_axis_tuser;
            if (plain_queue.size() == 0) begin
                $error("result with nothing expected: %h", m_axis_tdata);
                errors++;
            end else begin
                want = plain_queue.pop_front();
                if (got.plain !== want.plain) begin
                    $error("plaintext exp %h got %h", want.plain, got.plain); errors++;
                end
                if (got.secret !== want.secret) begin
                    $error("shared_secret exp %h got %h", want.secret, got.secret);
                    errors++;
                end
                if (got.zero !== want.zero) begin
                    $error("plaintext_zero exp %b got %b", want.zero, got.zero); errors++;
                end
            end
        end
    end

    // drop the input offer and wait for every expected result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (plain_queue.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == elg_pkg::REG_MODULUS) q_mod = val;
        else x_key = val;
        @(posedge aclk);
    endtask

    task automatic send_cipher(logic [W-1:0] c1, logic [W-1:0] c2, bit known = 0,
                               decrypt_result_t res = '0);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (hold_off && !hold_done) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c2, c1};
        @(posedge aclk iff s_axis_tready);
        plain_queue.push_back(known ? res : decrypt(c1, c2));
    endtask

    function automatic logic [W-1:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40);
            1: return '1 - $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    // key settings for the random phases: small, mid, large primes and composites
    logic [W-1:0] mod_set[6] = '{32'd23, 32'd3, 32'd65521, 32'd4294967291,
                                 32'd4294967295, 32'd1000};
    logic [W-1:0] key_set[6] = '{32'd2, 32'd7, 32'd4294967294, 32'd12345,
                                 32'hDEADBEEF, 32'd0};

    cipher_row_t table_rows[$];

    initial begin : sender
        decrypt_result_t r;
        q_mod = elg_pkg::RESET_MODULUS;
        x_key = elg_pkg::RESET_PRIVATE_KEY;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows under reset settings (q 23, x 2)
        table_rows.push_back('{32'd0, 32'd5, 1, '{32'd0, 32'd0, 1'b1}});
        table_rows.push_back('{32'd23, 32'd9, 1, '{32'd0, 32'd0, 1'b1}});
        table_rows.push_back('{32'd1, 32'd5, 1, '{32'd5, 32'd1, 1'b0}});
        table_rows.push_back('{32'd1, 32'd0, 1, '{32'd0, 32'd1, 1'b1}});
        table_rows.push_back('{32'd22, 32'd7, 1, '{32'd7, 32'd1, 1'b0}});
        table_rows.push_back('{32'd24, 32'd30, 1, '{32'd7, 32'd1, 1'b0}});
        table_rows.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 0, r});
        table_rows.push_back('{32'h0, 32'hFFFFFFFF, 0, r});
        table_rows.push_back('{32'hAAAAAAAA, 32'h55555555, 0, r});
        table_rows.push_back('{32'h55555555, 32'hAAAAAAAA, 0, r});
        table_rows.push_back('{32'd5, 32'd3, 0, r});
        foreach (table_rows[i])
            send_cipher(table_rows[i].c1, table_rows[i].c2, table_rows[i].known,
                        table_rows[i].res);
        drain();

        // extremes of the key registers
        write_reg(elg_pkg::REG_MODULUS, 32'hFFFFFFFB);
        write_reg(elg_pkg::REG_PRIVATE_KEY, 32'hFFFFFFFA);
        send_cipher(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_cipher(32'hFFFFFFFB, 32'd1);
        send_cipher(32'd2, 32'h80000000);
        drain();
        write_reg(elg_pkg::REG_MODULUS, 32'd1);
        send_cipher(32'd7, 32'd9, 1, '{32'd0, 32'd0, 1'b1});
        drain();
        write_reg(elg_pkg::REG_MODULUS, 32'd0);
        send_cipher(32'hFFFFFFFF, 32'd9, 1, '{32'd0, 32'd0, 1'b1});
        drain();

        // random phases across key settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(elg_pkg::REG_MODULUS, mod_set[ph]);
            write_reg(elg_pkg::REG_PRIVATE_KEY, key_set[ph]);
            if (ph == 2) hold_off = 1'b1;
            for (int n = 0; n < 37; n++) send_cipher(rand_word(), rand_word());
            drain();
        end

        repeat (3000) @(posedge aclk);
        if (errors == 0 && plain_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/elg_pkg.sv
src/elg_arith.sv
src/elg_ctrl.sv
src/elgamal_decrypt.sv
bench/elgamal_decrypt_test.sv
